// ----- hw/rtl/hdte_pkg.sv -----
// ----------------------------------------------------------------------------
// hdte_pkg
// Types, constants and decode functions shared by the date parser blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package hdte_pkg;

   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_WEEKDAY = 3'd1;
   localparam logic [2:0] ERR_MONTH   = 3'd2;
   localparam logic [2:0] ERR_DIGIT   = 3'd3;
   localparam logic [2:0] ERR_EARLY   = 3'd4;

   localparam int unsigned EPOCH_W = 39;

   localparam logic [6:0]  DAY_MAX      = 7'd99;
   localparam logic [13:0] YEAR_MAX     = 14'd9999;
   localparam logic [16:0] MUL_DIV100   = 17'd5243;
   localparam int unsigned DIV100_SHIFT = 19;
   localparam logic [16:0] MUL_100      = 17'd100;
   localparam logic [16:0] MUL_YEAR     = 17'd365;
   localparam logic [16:0] MUL_HOUR     = 17'd3600;
   localparam logic [16:0] MUL_DAY      = 17'd86400;
   localparam logic [16:0] MUL_MINUTE   = 17'd60;
   localparam logic [23:0] DAYS_TO_1970 = 24'd719529;

   typedef enum logic [18:0] {
      PH_WD0      = 19'h00001,
      PH_WD1      = 19'h00002,
      PH_WD2      = 19'h00004,
      PH_PREDAY   = 19'h00008,
      PH_DAY      = 19'h00010,
      PH_POSTDAY  = 19'h00020,
      PH_MON1     = 19'h00040,
      PH_MON2     = 19'h00080,
      PH_PREYEAR  = 19'h00100,
      PH_YEAR     = 19'h00200,
      PH_POSTYEAR = 19'h00400,
      PH_HOUR1    = 19'h00800,
      PH_SEP1     = 19'h01000,
      PH_MIN0     = 19'h02000,
      PH_MIN1     = 19'h04000,
      PH_SEP2     = 19'h08000,
      PH_SEC0     = 19'h10000,
      PH_SEC1     = 19'h20000,
      PH_DONE     = 19'h40000
   } phase_type;

   typedef enum logic [1:0] {
      SQ_IDLE = 2'b01,
      SQ_RUN  = 2'b10
   } seq_state_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
   } fields_type;

   typedef struct packed {
      logic       done;
      logic [2:0] code;
   } parse_status_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return (c == 8'h2C) || (c == 8'h20);
   endfunction

   function automatic logic wday_ok(input logic [23:0] key);
      logic ok;
      unique case (key)
         "Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun": ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   // {hit, index}
   function automatic logic [4:0] mon_lookup(input logic [23:0] key);
      logic [4:0] r;
      unique case (key)
         "Jan":   r = {1'b1, 4'd0};
         "Feb":   r = {1'b1, 4'd1};
         "Mar":   r = {1'b1, 4'd2};
         "Apr":   r = {1'b1, 4'd3};
         "May":   r = {1'b1, 4'd4};
         "Jun":   r = {1'b1, 4'd5};
         "Jul":   r = {1'b1, 4'd6};
         "Aug":   r = {1'b1, 4'd7};
         "Sep":   r = {1'b1, 4'd8};
         "Oct":   r = {1'b1, 4'd9};
         "Nov":   r = {1'b1, 4'd10};
         "Dec":   r = {1'b1, 4'd11};
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] d;
      unique case (m)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         default: d = 9'd334;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hdte_parse.sv -----
// ----------------------------------------------------------------------------
// hdte_parse
// Byte-serial parser: walks the date string and collects the date fields.
// ----------------------------------------------------------------------------
`default_nettype none

module hdte_parse (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       take,
   input  wire logic [7:0]                 char_in,
   input  wire logic                       is_last,
   output hdte_pkg::fields_type            fields,
   output hdte_pkg::parse_status_type      status
);
   import hdte_pkg::*;

   phase_type   phase_ff, phase_in, phase_up;
   logic [15:0] name_ff, name_in, name_up;
   fields_type  fld_ff, fld_in, fld_up;
   logic [2:0]  err_ff, err_in, err_up;

   logic        dig;
   logic        sep;
   logic [3:0]  dval;
   logic [9:0]  day_mul;
   logic [16:0] year_mul;
   logic [4:0]  mon;

   always_comb begin
      dig      = is_digit(char_in);
      sep      = is_sep(char_in);
      dval     = char_in[3:0];
      day_mul  = 10'(fld_ff.day) * 10'd10 + 10'(dval);
      year_mul = 17'(fld_ff.year) * 17'd10 + 17'(dval);
      mon      = mon_lookup({name_ff, char_in});
      phase_up = phase_ff;
      name_up  = name_ff;
      fld_up   = fld_ff;
      err_up   = err_ff;
      if (take && (err_ff == ERR_NONE) && (phase_ff != PH_DONE)) begin
         unique case (phase_ff)
            PH_WD0: begin
               name_up  = {char_in, 8'h00};
               phase_up = PH_WD1;
            end
            PH_WD1: begin
               name_up  = {name_ff[15:8], char_in};
               phase_up = PH_WD2;
            end
            PH_WD2: begin
               if (wday_ok({name_ff, char_in})) phase_up = PH_PREDAY;
               else err_up = ERR_WEEKDAY;
            end
            PH_PREDAY: begin
               if (sep) begin
                  phase_up = PH_PREDAY;
               end else if (dig) begin
                  fld_up.day = 7'(dval);
                  phase_up   = PH_DAY;
               end else begin
                  name_up  = {char_in, 8'h00};
                  phase_up = PH_MON1;
               end
            end
            PH_DAY: begin
               if (dig) begin
                  fld_up.day = (day_mul > 10'(DAY_MAX)) ? DAY_MAX : day_mul[6:0];
               end else if (sep) begin
                  phase_up = PH_POSTDAY;
               end else begin
                  name_up  = {char_in, 8'h00};
                  phase_up = PH_MON1;
               end
            end
            PH_POSTDAY: begin
               if (!sep) begin
                  name_up  = {char_in, 8'h00};
                  phase_up = PH_MON1;
               end
            end
            PH_MON1: begin
               name_up  = {name_ff[15:8], char_in};
               phase_up = PH_MON2;
            end
            PH_MON2: begin
               if (mon[4]) begin
                  fld_up.month = mon[3:0];
                  phase_up     = PH_PREYEAR;
               end else begin
                  err_up = ERR_MONTH;
               end
            end
            PH_PREYEAR, PH_YEAR, PH_POSTYEAR: begin
               if (sep) begin
                  if (phase_ff == PH_YEAR) phase_up = PH_POSTYEAR;
               end else if (dig && (phase_ff != PH_POSTYEAR)) begin
                  if (phase_ff == PH_PREYEAR) begin
                     fld_up.year = 14'(dval);
                     phase_up    = PH_YEAR;
                  end else begin
                     fld_up.year = (year_mul > 17'(YEAR_MAX)) ? YEAR_MAX
                                                              : year_mul[13:0];
                  end
               end else if (dig) begin
                  fld_up.hour = 7'(dval) * 7'd10;
                  phase_up    = PH_HOUR1;
               end else begin
                  err_up = ERR_DIGIT;
               end
            end
            PH_HOUR1: begin
               if (dig) begin
                  fld_up.hour = fld_ff.hour + 7'(dval);
                  phase_up    = PH_SEP1;
               end else begin
                  err_up = ERR_DIGIT;
               end
            end
            PH_SEP1: phase_up = PH_MIN0;
            PH_MIN0: begin
               if (dig) begin
                  fld_up.minute = 7'(dval) * 7'd10;
                  phase_up      = PH_MIN1;
               end else begin
                  err_up = ERR_DIGIT;
               end
            end
            PH_MIN1: begin
               if (dig) begin
                  fld_up.minute = fld_ff.minute + 7'(dval);
                  phase_up      = PH_SEP2;
               end else begin
                  err_up = ERR_DIGIT;
               end
            end
            PH_SEP2: phase_up = PH_SEC0;
            PH_SEC0: begin
               if (dig) begin
                  fld_up.second = 7'(dval) * 7'd10;
                  phase_up      = PH_SEC1;
               end else begin
                  err_up = ERR_DIGIT;
               end
            end
            PH_SEC1: begin
               if (dig) begin
                  fld_up.second = fld_ff.second + 7'(dval);
                  phase_up      = PH_DONE;
               end else begin
                  err_up = ERR_DIGIT;
               end
            end
            default: phase_up = phase_ff;
         endcase
      end

      fields      = fld_up;
      status.done = take && is_last;
      if (err_up != ERR_NONE)      status.code = err_up;
      else if (phase_up != PH_DONE) status.code = ERR_EARLY;
      else                          status.code = ERR_NONE;

      if (take && is_last) begin
         phase_in = PH_WD0;
         name_in  = '0;
         fld_in   = '0;
         err_in   = ERR_NONE;
      end else begin
         phase_in = phase_up;
         name_in  = name_up;
         fld_in   = fld_up;
         err_in   = err_up;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WD0;
         name_ff  <= '0;
         fld_ff   <= '0;
         err_ff   <= ERR_NONE;
      end else begin
         phase_ff <= phase_in;
         name_ff  <= name_in;
         fld_ff   <= fld_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/hdte_mul.sv -----
// ----------------------------------------------------------------------------
// hdte_mul
// Shared registered multiplier: signed 24-bit operand times unsigned 17-bit.
// ----------------------------------------------------------------------------
`default_nettype none

module hdte_mul (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [23:0] op_a,
   input  wire logic        [16:0] op_b,
   output      logic signed [41:0] prod
);

   logic signed [41:0] prod_ff, prod_in;

   assign prod_in = 42'(op_a) * 42'($signed({1'b0, op_b}));
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/hdte_seq.sv -----
// ----------------------------------------------------------------------------
// hdte_seq
// Conversion sequencer: date fields to seconds since 1970 on the shared
// multiplier, one product per step.
// ----------------------------------------------------------------------------
`default_nettype none

module hdte_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire hdte_pkg::fields_type   fields,
   input  wire logic                   out_free,
   output      logic                   busy,
   output      logic                   done,
   output      logic [38:0]            epoch
);
   import hdte_pkg::*;

   seq_state_type      state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   fields_type         fld_ff, fld_in;
   logic [6:0]         qy_ff, qy_in;
   logic [6:0]         qp_ff, qp_in;
   logic               leap_ff, leap_in;
   logic signed [23:0] days_ff, days_in;
   logic signed [41:0] acc_ff, acc_in;

   logic               mul_en;
   logic signed [23:0] op_a;
   logic        [16:0] op_b;
   logic signed [41:0] prod;
   logic [13:0]        yprev;
   logic               cent;
   logic [23:0]        lead;
   logic [23:0]        pos;
   logic signed [41:0] total;

   hdte_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   always_comb begin
      yprev = (fld_ff.year != 14'd0) ? fld_ff.year - 14'd1 : 14'd0;
      cent  = (prod[13:0] == fld_ff.year);
      lead  = (fld_ff.year != 14'd0)
              ? 24'(yprev[13:2]) - 24'(qp_ff) + 24'(qp_ff[6:2]) + 24'd1 : 24'd0;
      pos   = 24'(prod[21:0]) + lead + 24'(days_before(fld_ff.month))
              + 24'(leap_ff && (fld_ff.month >= 4'd2)) + 24'(fld_ff.day);
      total = acc_ff + prod + 42'(fld_ff.second);

      op_a = 24'(fld_ff.minute);
      op_b = MUL_MINUTE;
      case (step_ff)
         3'd0: begin
            op_a = 24'(fld_ff.year);
            op_b = MUL_DIV100;
         end
         3'd1: begin
            op_a = 24'(yprev);
            op_b = MUL_DIV100;
         end
         3'd2: begin
            op_a = 24'(qy_ff);
            op_b = MUL_100;
         end
         3'd3: begin
            op_a = 24'(fld_ff.year);
            op_b = MUL_YEAR;
         end
         3'd4: begin
            op_a = 24'(fld_ff.hour);
            op_b = MUL_HOUR;
         end
         3'd5: begin
            op_a = days_ff;
            op_b = MUL_DAY;
         end
         default: begin
            op_a = 24'(fld_ff.minute);
            op_b = MUL_MINUTE;
         end
      endcase

      state_in = state_ff;
      step_in  = step_ff;
      fld_in   = fld_ff;
      qy_in    = qy_ff;
      qp_in    = qp_ff;
      leap_in  = leap_ff;
      days_in  = days_ff;
      acc_in   = acc_ff;
      done     = 1'b0;
      mul_en   = 1'b0;

      unique case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               fld_in   = fields;
               step_in  = 3'd0;
               state_in = SQ_RUN;
            end
         end
         SQ_RUN: begin
            mul_en  = 1'b1;
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd1: qy_in = prod[DIV100_SHIFT +: 7];
               3'd2: qp_in = prod[DIV100_SHIFT +: 7];
               3'd3: leap_in = ((fld_ff.year[1:0] == 2'd0) && !cent)
                               || (cent && (qy_ff[1:0] == 2'd0));
               3'd4: days_in = $signed(pos - DAYS_TO_1970);
               3'd5: acc_in = prod;
               3'd6: acc_in = acc_ff + prod;
               3'd7: begin
                  if (out_free) begin
                     done     = 1'b1;
                     state_in = SQ_IDLE;
                  end else begin
                     mul_en  = 1'b0;
                     step_in = step_ff;
                  end
               end
               default: step_in = step_ff + 3'd1;
            endcase
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   assign busy  = (state_ff == SQ_RUN);
   assign epoch = total[EPOCH_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      fld_ff  <= fld_in;
      qy_ff   <= qy_in;
      qp_ff   <= qp_in;
      leap_ff <= leap_in;
      days_ff <= days_in;
      acc_ff  <= acc_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/http_date_to_epoch_parser_top.sv -----
// ----------------------------------------------------------------------------
// http_date_to_epoch_parser_top
// HTTP date string, one byte per transfer, to seconds since 1970 UTC.
//
//   Channel  Dir  Payload                                   End of string
//   req_     in   tdata[7:0] char_in                        tlast
//   rsp_     out  tdata[38:0] epoch_seconds, [41:39] code   one per string
//
// Each byte but the last is taken when offered, unless the output holds it off.
// A last byte whose string failed or ended early gives its result on the next
// cycle; otherwise the sequencer runs on the shared multiplier until done.
// Reset is synchronous and clears the parser and the sequencer.
// A stalled result holds in the output register and holds off every byte
// until it is taken; the sequencer waits in its last step meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module http_date_to_epoch_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_in
   input  wire logic        req_tlast,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata    // [38:0] epoch_seconds, [41:39] error_code
);
   import hdte_pkg::*;

   logic             take;
   logic             out_free;
   logic             busy;
   logic             seq_done;
   logic [38:0]      seq_epoch;
   fields_type       fields;
   parse_status_type status;

   logic             valid_ff, valid_in;
   logic [38:0]      epoch_ff, epoch_in;
   logic [2:0]       code_ff, code_in;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = !busy && out_free;
   assign take       = req_tvalid && req_tready;

   hdte_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .char_in (req_tdata),
      .is_last (req_tlast),
      .fields  (fields),
      .status  (status)
   );

   hdte_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (status.done && (status.code == ERR_NONE)),
      .fields   (fields),
      .out_free (out_free),
      .busy     (busy),
      .done     (seq_done),
      .epoch    (seq_epoch)
   );

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      epoch_in = epoch_ff;
      code_in  = code_ff;
      if (status.done && (status.code != ERR_NONE)) begin
         valid_in = 1'b1;
         epoch_in = '1;
         code_in  = status.code;
      end else if (seq_done) begin
         valid_in = 1'b1;
         epoch_in = seq_epoch;
         code_in  = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      epoch_ff <= epoch_in;
      code_ff  <= code_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'b0, code_ff, epoch_ff};

endmodule

`default_nettype wire

// ----- hw/rtl/hdte_checker.sv -----
// ----------------------------------------------------------------------------
// hdte_checker
// Port-level checks on the date parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hdte_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);
   import hdte_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_err_epoch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[41:39] != ERR_NONE) |-> (&rsp_tdata[38:0]))
      else $error("error result without all-ones epoch");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[41:39] <= ERR_EARLY) && (rsp_tdata[47:42] == 6'd0))
      else $error("bad error code or padding");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result without last byte");

endmodule

bind http_date_to_epoch_parser_top hdte_checker u_hdte_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
